/* rtl/msrs_pkg.sv */
`default_nettype none
package msrs_pkg;
    localparam int MaxPoints  = 1024;
    localparam int MaxMatches = 64;
    localparam int CoordBits  = 24;
    localparam int AddrW      = $clog2(MaxPoints);
    localparam int CntW       = AddrW + 1;
    localparam int MatchW     = $clog2(MaxMatches + 1);
    localparam int CodeW      = 64;
    localparam int IdentW     = 10;
    localparam int RadW       = 23;
    localparam int DiffW      = CoordBits + 1;
    localparam int SqW        = 2 * DiffW;
    localparam int SumW       = SqW + 2;

    localparam int InDataW  = 288;
    localparam int OutDataW = 24;
    localparam int CfgIdxW  = 1;
    localparam int CfgDataW = 23;

    localparam logic [CfgIdxW-1:0] RegPointCount  = 1'd0;
    localparam logic [CfgIdxW-1:0] RegSearchRadius = 1'd1;

    localparam logic OpLoad  = 1'b0;
    localparam logic OpQuery = 1'b1;

    // One point as held in the store.
    typedef struct packed {
        logic [CodeW-1:0]     code;
        logic [CoordBits-1:0] x;
        logic [CoordBits-1:0] y;
        logic [CoordBits-1:0] z;
        logic [IdentW-1:0]    ident;
    } t_point;

    // Result item handed to the output stage.
    typedef struct packed {
        logic [IdentW-1:0] match_id;
        logic              match_valid;
        logic              last;
        logic              truncated;
        logic [CntW-1:0]   checked;
    } t_result;
endpackage
`default_nettype wire

/* rtl/msrs_store.sv */
`default_nettype none
module msrs_store (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [msrs_pkg::AddrW-1:0] i_waddr,
    input  wire msrs_pkg::t_point           i_wdata,
    input  wire logic [msrs_pkg::AddrW-1:0] i_raddr,
    output msrs_pkg::t_point                o_rdata
);
    import msrs_pkg::*;

    t_point r_mem [MaxPoints];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* rtl/msrs_dist.sv */
`default_nettype none
// Two-stage distance test: absolute differences and the per-axis bound, then
// the squares summed and compared against the squared radius.
module msrs_dist (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    input  wire logic [msrs_pkg::CoordBits-1:0] i_px,
    input  wire logic [msrs_pkg::CoordBits-1:0] i_py,
    input  wire logic [msrs_pkg::CoordBits-1:0] i_pz,
    input  wire logic [msrs_pkg::IdentW-1:0]    i_ident,
    input  wire logic [msrs_pkg::CoordBits-1:0] i_qx,
    input  wire logic [msrs_pkg::CoordBits-1:0] i_qy,
    input  wire logic [msrs_pkg::CoordBits-1:0] i_qz,
    input  wire logic [msrs_pkg::RadW-1:0]      i_radius,
    output logic                                o_valid,
    output logic                                o_hit,
    output logic [msrs_pkg::IdentW-1:0]         o_ident
);
    import msrs_pkg::*;

    logic [DiffW-1:0] w_dx, w_dy, w_dz;
    logic             w_near;
    logic             r_v1;
    logic             r_near;
    logic [DiffW-1:0] r_dx, r_dy, r_dz;
    logic [IdentW-1:0] r_id1;
    logic [SumW-1:0]  w_sum;
    logic [SumW-1:0]  w_r2;

    function automatic logic [DiffW-1:0] f_absdiff(logic [CoordBits-1:0] a,
                                                   logic [CoordBits-1:0] b);
        logic signed [DiffW-1:0] d;
        d = DiffW'($signed(a)) - DiffW'($signed(b));
        return d[DiffW-1] ? DiffW'(-d) : DiffW'(d);
    endfunction

    assign w_dx   = f_absdiff(i_px, i_qx);
    assign w_dy   = f_absdiff(i_py, i_qy);
    assign w_dz   = f_absdiff(i_pz, i_qz);
    assign w_near = (w_dx <= DiffW'(i_radius)) && (w_dy <= DiffW'(i_radius))
                 && (w_dz <= DiffW'(i_radius));
    assign w_sum  = SumW'(r_dx * r_dx) + SumW'(r_dy * r_dy) + SumW'(r_dz * r_dz);
    assign w_r2   = SumW'(i_radius * i_radius);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v1    <= i_valid;
            o_valid <= r_v1;
        end
        r_near  <= w_near;
        r_dx    <= w_dx;
        r_dy    <= w_dy;
        r_dz    <= w_dz;
        r_id1   <= i_ident;
        o_hit   <= r_near && (w_sum <= w_r2);
        o_ident <= r_id1;
    end
endmodule
`default_nettype wire

/* rtl/morton_sorted_radius_search.sv */
`default_nettype none
// Morton-ordered radius neighbour search.
// One input stream carries load and query items; one output stream returns
// the results. A load (op = 0) writes a point into the store. A query
// (op = 1) runs a lower-bound binary search on range_lo and an upper-bound
// binary search on range_hi, each one store read per step. It then scans
// the span one candidate at a time, since each candidate waits out the
// two-stage distance unit before the next one is read. The single store
// read port and the wait on the distance unit set the pace of a query; the
// input stream is not ready again until its final result is loaded. Every
// query ends with one transfer carrying tlast; a query with no matches sends
// one empty transfer. At most MaxMatches match transfers are made; further
// matches set the truncated flag instead.
// Reset clears the control state and both registers; the store has no
// reset and must be loaded before it is searched. When the receiver stalls,
// the scan waits until the output register is free, and the final transfer
// waits until it is empty; no result is lost.
// The user must write the registers through i_cfg_we only while the block
// is idle; the block itself does not enforce this.
module morton_sorted_radius_search (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [msrs_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [msrs_pkg::CfgDataW-1:0] i_cfg_data,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // op, slot, point_code, coord_x, coord_y, coord_z, point_ident,
    // range_lo, range_hi (lowest bit first)
    input  wire logic [msrs_pkg::InDataW-1:0]  s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // match_id, match_valid, truncated, candidates_checked, zero pad
    output logic [msrs_pkg::OutDataW-1:0]      m_axis_tdata,
    output logic                               m_axis_tlast
);
    import msrs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_LB_RD, S_LB_CMP, S_UB_RD, S_UB_CMP, S_SCAN_RD, S_SCAN_CMP, S_DRAIN
    } t_state;

    t_state r_state;
    logic [CntW-1:0]      r_point_count;
    logic [RadW-1:0]      r_radius;
    logic [CntW-1:0]      r_lo, r_hi, r_start, r_idx;
    logic [CodeW-1:0]     r_key_lo, r_key_hi;
    logic [CoordBits-1:0] r_qx, r_qy, r_qz;
    logic [MatchW-1:0]    r_emitted;
    logic [CntW-1:0]      r_checked;
    logic                 r_trunc;
    logic [1:0]           r_drain;
    logic                 r_pend_v;
    logic [IdentW-1:0]    r_pend_id;
    logic                 r_out_v;
    t_result              r_out;

    logic                 w_op;
    logic [AddrW-1:0]     w_slot;
    t_point               w_wr, w_rd;
    logic [CntW-1:0]      w_n, w_mid;
    logic [AddrW-1:0]     w_raddr;
    logic                 w_in_acc, w_out_acc, w_out_free;
    logic                 w_dvalid, w_dhit;
    logic [IdentW-1:0]    w_did;
    logic                 w_issue;

    assign w_op   = s_axis_tdata[0];
    assign w_slot = s_axis_tdata[AddrW:1];
    assign w_wr.code  = s_axis_tdata[74:11];
    assign w_wr.x     = s_axis_tdata[98:75];
    assign w_wr.y     = s_axis_tdata[122:99];
    assign w_wr.z     = s_axis_tdata[146:123];
    assign w_wr.ident = s_axis_tdata[156:147];

    assign w_n = (r_point_count > CntW'(MaxPoints)) ? CntW'(MaxPoints) : r_point_count;
    assign w_mid = r_lo + ((r_hi - r_lo) >> 1);
    assign w_raddr = (r_state == S_SCAN_RD) ? r_idx[AddrW-1:0] : w_mid[AddrW-1:0];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_out_acc  = r_out_v && m_axis_tready;
    assign w_out_free = !r_out_v || m_axis_tready;
    assign w_issue    = (r_state == S_SCAN_CMP);

    msrs_store u_store (
        .i_clk  (i_clk),
        .i_we   (w_in_acc && (w_op == OpLoad)),
        .i_waddr(w_slot),
        .i_wdata(w_wr),
        .i_raddr(w_raddr),
        .o_rdata(w_rd)
    );

    msrs_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_issue),
        .i_px    (w_rd.x),
        .i_py    (w_rd.y),
        .i_pz    (w_rd.z),
        .i_ident (w_rd.ident),
        .i_qx    (r_qx),
        .i_qy    (r_qy),
        .i_qz    (r_qz),
        .i_radius(r_radius),
        .o_valid (w_dvalid),
        .o_hit   (w_dhit),
        .o_ident (w_did)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_point_count <= '0;
            r_radius      <= '0;
            r_out_v       <= 1'b0;
            r_pend_v      <= 1'b0;
            r_emitted     <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    RegPointCount:   r_point_count <= i_cfg_data[CntW-1:0];
                    RegSearchRadius: r_radius      <= i_cfg_data[RadW-1:0];
                    default: ;
                endcase
            end
            if (w_out_acc) begin
                r_out_v <= 1'b0;
            end
            // A hit is held one behind so the final one can carry tlast.
            if (w_dvalid && w_dhit) begin
                if (r_emitted == MatchW'(MaxMatches)) begin
                    r_trunc <= 1'b1;
                end else begin
                    r_emitted <= r_emitted + 1'b1;
                    if (r_pend_v) begin
                        r_out_v <= 1'b1;
                        r_out   <= '{r_pend_id, 1'b1, 1'b0, 1'b0, '0};
                    end
                    r_pend_v  <= 1'b1;
                    r_pend_id <= w_did;
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc && (w_op == OpQuery)) begin
                        r_qx      <= s_axis_tdata[98:75];
                        r_qy      <= s_axis_tdata[122:99];
                        r_qz      <= s_axis_tdata[146:123];
                        r_key_lo  <= s_axis_tdata[220:157];
                        r_key_hi  <= s_axis_tdata[284:221];
                        r_lo      <= '0;
                        r_hi      <= w_n;
                        r_emitted <= '0;
                        r_checked <= '0;
                        r_trunc   <= 1'b0;
                        r_state   <= S_LB_RD;
                    end
                end
                S_LB_RD: begin
                    r_state <= (r_lo < r_hi) ? S_LB_CMP : S_UB_RD;
                    if (!(r_lo < r_hi)) begin
                        r_start <= r_lo;
                        r_lo    <= '0;
                        r_hi    <= w_n;
                    end
                end
                S_LB_CMP: begin
                    if (w_rd.code < r_key_lo) r_lo <= w_mid + 1'b1;
                    else                      r_hi <= w_mid;
                    r_state <= S_LB_RD;
                end
                S_UB_RD: begin
                    if (r_lo < r_hi) begin
                        r_state <= S_UB_CMP;
                    end else begin
                        r_idx   <= r_start;
                        r_hi    <= r_lo;
                        r_state <= S_SCAN_RD;
                    end
                end
                S_UB_CMP: begin
                    if (w_rd.code <= r_key_hi) r_lo <= w_mid + 1'b1;
                    else                       r_hi <= w_mid;
                    r_state <= S_UB_RD;
                end
                S_SCAN_RD: begin
                    if (r_idx < r_hi) begin
                        // Only advance with room downstream: at most two in flight.
                        if (w_out_free && !(r_pend_v && r_out_v)) begin
                            r_state <= S_SCAN_CMP;
                        end
                    end else begin
                        r_drain <= 2'd3;
                        r_state <= S_DRAIN;
                    end
                end
                S_SCAN_CMP: begin
                    r_checked <= r_checked + 1'b1;
                    r_idx     <= r_idx + 1'b1;
                    r_drain   <= 2'd3;
                    r_state   <= S_DRAIN;
                end
                S_DRAIN: begin
                    if (r_drain != 2'd0) begin
                        r_drain <= r_drain - 1'b1;
                    end else if (r_idx < r_hi) begin
                        r_state <= S_SCAN_RD;
                    end else if (!r_out_v) begin
                        r_out_v  <= 1'b1;
                        r_out    <= '{r_pend_v ? r_pend_id : '0, r_pend_v, 1'b1,
                                      r_trunc, r_checked};
                        r_pend_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {r_out.checked, r_out.truncated, r_out.match_valid,
                            r_out.match_id} ;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !m_axis_tready) |=> $stable(r_out))
        else $error("output changed while stalled");
    a_emit_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emitted <= MatchW'(MaxMatches))
        else $error("match count past limit");
    a_busy_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready)
        else $error("ready while busy");
endmodule
`default_nettype wire

/* dv/tb.sv */
`default_nettype none
// Stimulus and checking for the Morton-ordered radius neighbour search.
//
// An initial block builds sets of points whose codes are sorted (and once
// deliberately unsorted), writes the two registers while the block is idle,
// and queues load and query items. A clocked driver takes those items one at
// a time and offers them on the input stream with random gaps; a clocked
// receiver applies random back-pressure on the output stream. Every accepted
// transfer on the input side is applied to a mirror of the point store kept
// here, and each accepted query is searched against that mirror to give the
// list of results the block should return. The monitor compares every output
// transfer against the oldest outstanding result, field by field.
module tb;
    import msrs_pkg::*;

    localparam int WatchLimit = 40000;
    localparam int HoldCycles = 400;

    // One input item, with every field of the input stream.
    typedef struct {
        bit        op;
        bit [9:0]  slot;
        bit [63:0] code;
        bit [23:0] x;
        bit [23:0] y;
        bit [23:0] z;
        bit [9:0]  ident;
        bit [63:0] lo;
        bit [63:0] hi;
    } search_item_t;

    // One result as it should appear on the output stream.
    typedef struct {
        bit [9:0]  id;
        bit        valid;
        bit        last;
        bit        trunc;
        bit [10:0] checked;
    } hit_t;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CfgIdxW-1:0]  i_cfg_index;
    logic [CfgDataW-1:0] i_cfg_data;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [InDataW-1:0]  s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OutDataW-1:0] m_axis_tdata;
    logic                m_axis_tlast;

    morton_sorted_radius_search u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // op, slot, point_code, coord_x, coord_y, coord_z, point_ident,
        // range_lo, range_hi (lowest bit first)
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // match_id, match_valid, truncated, candidates_checked, zero pad
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Items waiting to be offered, and results still owed by the block.
    search_item_t pending_items[$];
    hit_t         owed_hits[$];

    // Mirror of the point store and of both registers.
    bit [63:0] st_code [MaxPoints];
    bit [23:0] st_x    [MaxPoints];
    bit [23:0] st_y    [MaxPoints];
    bit [23:0] st_z    [MaxPoints];
    bit [9:0]  st_ident[MaxPoints];
    int unsigned mir_count;
    int unsigned mir_radius;

    // Codes of the current point set, used to aim query intervals.
    bit [63:0] set_codes[$];

    search_item_t offer;
    bit          offering;
    int          send_gap;
    int          recv_gap;
    int          hold_left;
    bit          hold_req;
    bit          hold_taken;
    bit          no_idle;
    bit          in_done;
    bit          out_done;
    int          idle_cycles;
    int          errors;
    int          item_total;

    function automatic logic [InDataW-1:0] pack_item(search_item_t it);
        logic [287:0] v;
        v = {3'b0, it.hi, it.lo, it.ident, it.z, it.y, it.x, it.code, it.slot, it.op};
        return v[InDataW-1:0];
    endfunction

    // Lower bound (exclusive compare) or upper bound (inclusive compare).
    function automatic int span_edge(int n, bit [63:0] key, bit incl);
        int        lo_i;
        int        hi_i;
        int        mid;
        bit [63:0] c;
        lo_i = 0;
        hi_i = n;
        while (lo_i < hi_i) begin
            mid = lo_i + ((hi_i - lo_i) >> 1);
            c   = st_code[mid];
            if (incl ? (c <= key) : (c < key)) lo_i = mid + 1;
            else hi_i = mid;
        end
        return lo_i;
    endfunction

    function automatic longint axis_gap(bit [23:0] a, bit [23:0] b);
        longint d;
        d = longint'($signed(a)) - longint'($signed(b));
        return (d < 0) ? -d : d;
    endfunction

    // Applies one accepted item to the mirror and queues the results it owes.
    task automatic apply_item(search_item_t it);
        int     n;
        int     first;
        int     stop;
        int     hits;
        int     seen;
        bit     dropped;
        longint r;
        longint dx;
        longint dy;
        longint dz;
        hit_t   h;
        if (it.op == OpLoad) begin
            st_code[it.slot]  = it.code;
            st_x[it.slot]     = it.x;
            st_y[it.slot]     = it.y;
            st_z[it.slot]     = it.z;
            st_ident[it.slot] = it.ident;
            return;
        end
        n       = (mir_count > MaxPoints) ? MaxPoints : mir_count;
        r       = mir_radius;
        first   = span_edge(n, it.lo, 1'b0);
        stop    = span_edge(n, it.hi, 1'b1);
        hits    = 0;
        seen    = 0;
        dropped = 1'b0;
        for (int i = first; i < stop; i++) begin
            seen++;
            dx = axis_gap(st_x[i], it.x);
            dy = axis_gap(st_y[i], it.y);
            dz = axis_gap(st_z[i], it.z);
            if (dx > r || dy > r || dz > r) continue;
            if (dx * dx + dy * dy + dz * dz > r * r) continue;
            if (hits < MaxMatches) begin
                h = '{id: st_ident[i], valid: 1'b1, last: 1'b0, trunc: 1'b0, checked: '0};
                owed_hits.push_back(h);
                hits++;
            end else begin
                dropped = 1'b1;
            end
        end
        if (hits == 0) begin
            h = '{id: '0, valid: 1'b0, last: 1'b0, trunc: 1'b0, checked: '0};
            owed_hits.push_back(h);
        end
        h         = owed_hits.pop_back();
        h.last    = 1'b1;
        h.trunc   = dropped;
        h.checked = seen[10:0];
        owed_hits.push_back(h);
    endtask

    task automatic report(string what, longint got, longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        errors++;
    endtask

    // Transfers are recognised at the rising edge; the flags are read by the
    // falling-edge processes that drive the next values.
    always @(posedge i_clk) begin
        logic [23:0] ext;
        hit_t        want;
        in_done  <= i_rst_n && s_axis_tvalid && s_axis_tready;
        out_done <= i_rst_n && m_axis_tvalid && m_axis_tready;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                apply_item(offer);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                ext = 24'(m_axis_tdata);
                if (owed_hits.size() == 0) begin
                    $display("unexpected result at %0t: id %0d", $time, ext[9:0]);
                    errors++;
                end else begin
                    want = owed_hits.pop_front();
                    if (ext[9:0] != want.id) report("match_id", ext[9:0], want.id);
                    if (ext[10] != want.valid) report("match_valid", ext[10], want.valid);
                    if (m_axis_tlast != want.last) report("last", m_axis_tlast, want.last);
                    if (ext[11] != want.trunc) report("truncated", ext[11], want.trunc);
                    if (ext[22:12] != want.checked)
                        report("candidates_checked", ext[22:12], want.checked);
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WatchLimit) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Sender: one item at a time, a random gap before each.
    always @(negedge i_clk) begin
        bit busy;
        busy = offering;
        if (!i_rst_n) begin
            busy = 1'b0;
        end else begin
            if (busy && in_done) begin
                busy     = 1'b0;
                send_gap = no_idle ? 0 : $urandom_range(0, 11);
            end
            if (!busy) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_items.size() != 0) begin
                    offer = pending_items.pop_front();
                    busy  = 1'b1;
                end
            end
        end
        offering      = busy;
        s_axis_tvalid <= busy;
        s_axis_tdata  <= pack_item(offer);
    end

    // Receiver: a random stall before each result, and one long hold-off
    // when requested so that the block backs up onto its input.
    always @(negedge i_clk) begin
        if (hold_req && !hold_taken) begin
            hold_left  = HoldCycles;
            hold_taken = 1'b1;
        end
        if (out_done) recv_gap = no_idle ? 0 : $urandom_range(0, 11);
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Waits until every item has been taken and every result returned, then
    // lets the block finish before a register write.
    task automatic settle();
        while (pending_items.size() != 0 || offering || owed_hits.size() != 0)
            @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CfgIdxW-1:0] idx, int unsigned value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[CfgDataW-1:0];
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == RegPointCount) mir_count = value & 32'h7ff;
        else mir_radius = value & 32'h7fffff;
    endtask

    function automatic bit [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic bit [23:0] near(bit [23:0] centre, int unsigned spread);
        return centre + 24'($urandom_range(0, 2 * spread)) - 24'(spread);
    endfunction

    task automatic push_load(int slot, bit [63:0] code, bit [23:0] x, bit [23:0] y,
                             bit [23:0] z, bit [9:0] ident);
        search_item_t it;
        it       = '{default: '0};
        it.op    = OpLoad;
        it.slot  = slot[9:0];
        it.code  = code;
        it.x     = x;
        it.y     = y;
        it.z     = z;
        it.ident = ident;
        pending_items.push_back(it);
        item_total++;
    endtask

    task automatic push_query(bit [63:0] lo, bit [63:0] hi, bit [23:0] x, bit [23:0] y,
                              bit [23:0] z);
        search_item_t it;
        it      = '{default: '0};
        it.op   = OpQuery;
        it.x    = x;
        it.y    = y;
        it.z    = z;
        it.lo   = lo;
        it.hi   = hi;
        it.slot = 10'($urandom());
        pending_items.push_back(it);
        item_total++;
    endtask

    // Loads n points clustered about a centre. Codes are sorted unless the
    // set is meant to test a store that is out of order; a narrow code mask
    // gives many equal codes.
    task automatic load_set(int n, bit [23:0] centre, int unsigned spread,
                            bit [63:0] code_mask, bit sorted);
        set_codes.delete();
        for (int i = 0; i < n; i++) begin
            if (i > 0 && $urandom_range(0, 7) == 0) set_codes.push_back(set_codes[i - 1]);
            else set_codes.push_back(rand64() & code_mask);
        end
        if (sorted) set_codes.sort();
        for (int i = 0; i < n; i++)
            push_load(i, set_codes[i], near(centre, spread), near(centre, spread),
                      near(centre, spread), 10'($urandom()));
    endtask

    // A query aimed at the current set: mostly a span between two stored
    // codes, sometimes everything, an inverted interval or random bounds.
    task automatic random_query(bit [23:0] centre, int unsigned spread);
        int        n;
        int        a;
        int        b;
        bit [63:0] lo;
        bit [63:0] hi;
        n = set_codes.size();
        a = $urandom_range(0, n - 1);
        b = $urandom_range(a, n - 1);
        case ($urandom_range(0, 9))
            0: begin
                lo = '0;
                hi = '1;
            end
            1: begin
                lo = set_codes[b] + 1;
                hi = set_codes[a];
            end
            2: begin
                lo = rand64();
                hi = rand64();
            end
            default: begin
                lo = set_codes[a] - $urandom_range(0, 1);
                hi = set_codes[b] + $urandom_range(0, 1);
            end
        endcase
        push_query(lo, hi, near(centre, spread), near(centre, spread), near(centre, spread));
    endtask

    initial begin
        bit [23:0]   centre;
        int unsigned spread;
        int          n;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        mir_count     = 0;
        mir_radius    = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Registers at their reset values: an empty store gives the empty
        // final result with nothing checked.
        push_query('0, '1, 24'h000000, 24'h7fffff, 24'h800000);
        settle();

        // A small set with radius zero: only exact coincidence matches.
        write_reg(RegPointCount, 8);
        write_reg(RegSearchRadius, 0);
        centre = 24'h000100;
        load_set(8, centre, 2, 64'h0000_0000_0000_00ff, 1'b1);
        push_load(8, '1, 24'h7fffff, 24'h7fffff, 24'h7fffff, 10'h3ff);
        settle();
        push_query('0, '1, centre, centre, centre);
        push_query(set_codes[0], set_codes[7], 24'h800000, 24'h800000, 24'h800000);
        push_query(set_codes[5], set_codes[2], centre, centre, centre);
        push_query(set_codes[3], set_codes[3], centre, centre, centre);
        settle();

        // Largest radius with opposite extremes of the coordinate range, so
        // single axes exceed the radius.
        write_reg(RegSearchRadius, 23'h7fffff);
        push_load(0, '0, 24'h800000, 24'h7fffff, 24'h000000, 10'h000);
        push_load(1, 64'h8000_0000_0000_0000, 24'h7fffff, 24'h800000, 24'h000000, 10'h2aa);
        push_load(2, '1, 24'h000000, 24'h000000, 24'h000000, 10'h155);
        push_query('0, '1, 24'h800000, 24'h7fffff, 24'h000000);
        push_query('0, '1, 24'h7fffff, 24'h7fffff, 24'h7fffff);
        push_query('1, '0, 24'h000000, 24'h000000, 24'h000000);
        settle();

        // A large set: many matches, truncation and long scans. The
        // receiver holds off while queries keep coming.
        write_reg(RegPointCount, 130);
        centre = 24'($urandom());
        load_set(130, centre, 4000, '1, 1'b1);
        settle();
        hold_req = 1'b1;
        for (int i = 0; i < 4; i++) random_query(centre, 3000);
        push_query('0, '1, centre, centre, centre);
        settle();
        // A count beyond the store size is clamped to the store size. An
        // interval at code zero walks down from the middle of the store, so
        // only the middle and quarter entries beyond the set need loading.
        write_reg(RegPointCount, 11'h7ff);
        push_load(256, '1, centre, centre, centre, 10'h111);
        push_load(512, '1, centre, centre, centre, 10'h222);
        push_query('0, '0, centre, centre, centre);
        settle();

        // Random sets: mostly sorted and clustered, one unsorted, with
        // rewrites of points that keep their codes.
        for (int phase = 0; item_total < 360 || phase < 4; phase++) begin
            no_idle = (phase % 4 == 2);
            n       = $urandom_range(1, 40);
            spread  = $urandom_range(1, 1 << $urandom_range(4, 22));
            centre  = 24'($urandom());
            write_reg(RegPointCount, n);
            case ($urandom_range(0, 3))
                0: write_reg(RegSearchRadius, 0);
                1: write_reg(RegSearchRadius, $urandom_range(0, 2 * spread));
                2: write_reg(RegSearchRadius, 23'($urandom()));
                default: write_reg(RegSearchRadius, $urandom_range(spread, 3 * spread));
            endcase
            load_set(n, centre, spread, ($urandom_range(0, 2) == 0) ? 64'hff : '1,
                     phase != 1);
            for (int q = 0; q < 20; q++) begin
                if ($urandom_range(0, 5) == 0) begin
                    int s;
                    s = $urandom_range(0, n - 1);
                    push_load(s, set_codes[s], near(centre, spread), near(centre, spread),
                              near(centre, spread), 10'($urandom()));
                end else begin
                    random_query(centre, spread);
                end
            end
            settle();
        end
        no_idle = 1'b0;

        settle();
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
